/* rtl/core/vvp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vvp_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH_DEF = 256;
    localparam int SCREEN_HEIGHT    = 128;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COS_YAW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_YAW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF_FOV = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_PLANE    = 3'd6;

    // field widths
    localparam int COORD_W = 32;
    localparam int TRIG_W  = 16;
    localparam int TAN_W   = 24;
    localparam int FAR_W   = 31;

    // datapath widths
    localparam int DIFF_W    = COORD_W + 1;          // viewer-relative coordinate
    localparam int PROD_W    = DIFF_W + TRIG_W;      // coordinate times Q2.14 trig
    localparam int SUM_W     = PROD_W + 1;
    localparam int ROT_SHIFT = 14;
    localparam int ROT_W     = SUM_W - ROT_SHIFT;    // rotated coordinate
    localparam int BOUND_W   = 60;                   // tan * depth, Q.32
    localparam int FRAC_W    = 16;
    localparam int DEN_W     = 56;                   // 2 * bound when projected
    localparam int SY_QW     = 16;                   // row quotient bits before saturation
    localparam int SX_OUT_W  = 9;
    localparam int SY_OUT_W  = 16;

    localparam logic signed [ROT_W-1:0]   NEAR_DEPTH     = 36'sd655;
    localparam logic signed [COORD_W-1:0] NO_PROJ_DEPTH  = -32'sd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [SX_OUT_W-1:0] screen_x;
        logic signed [SY_OUT_W-1:0] screen_y;
        logic signed [COORD_W-1:0]  view_depth;
        logic                       projected;
        logic                       within_distance;
        logic                       within_x;
        logic                       within_y;
        logic                       dot_visible;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] viewer_x;
        logic signed [COORD_W-1:0] viewer_y;
        logic signed [COORD_W-1:0] viewer_z;
        logic signed [TRIG_W-1:0]  cos_yaw;
        logic signed [TRIG_W-1:0]  sin_yaw;
        logic [TAN_W-1:0]          tan_half_fov;
        logic [FAR_W-1:0]          far_plane;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        viewer_x:     32'sd0,
        viewer_y:     32'sd0,
        viewer_z:     32'sd0,
        cos_yaw:      16'sd16384,
        sin_yaw:      16'sd0,
        tan_half_fov: 24'd65536,
        far_plane:    31'd6553600
    };

    // per-vertex flags and depth riding alongside the divider
    typedef struct packed {
        logic                 projected;
        logic                 within_distance;
        logic                 within_x;
        logic                 within_y;
        logic                 neg_x;
        logic                 neg_y;
        logic [COORD_W-1:0]   depth;
    } side_t;

endpackage

`default_nettype wire

/* rtl/core/vvp_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module vvp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vvp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vvp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output vvp_pkg::cfg_t                    cfg
);

    vvp_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= vvp_pkg::CFG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                vvp_pkg::REG_VIEWER_X:     cfg_reg.viewer_x     <= $signed(cfg_data);
                vvp_pkg::REG_VIEWER_Y:     cfg_reg.viewer_y     <= $signed(cfg_data);
                vvp_pkg::REG_VIEWER_Z:     cfg_reg.viewer_z     <= $signed(cfg_data);
                vvp_pkg::REG_COS_YAW:      cfg_reg.cos_yaw      <= $signed(cfg_data[15:0]);
                vvp_pkg::REG_SIN_YAW:      cfg_reg.sin_yaw      <= $signed(cfg_data[15:0]);
                vvp_pkg::REG_TAN_HALF_FOV: cfg_reg.tan_half_fov <= cfg_data[23:0];
                vvp_pkg::REG_FAR_PLANE:    cfg_reg.far_plane    <= cfg_data[30:0];
                default:                   ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/vvp_transform.sv */
`timescale 1ns / 1ps
`default_nettype none

module vvp_transform #(
    parameter  int SCREEN_WIDTH = vvp_pkg::SCREEN_WIDTH_DEF,
    localparam int W_BITS       = $clog2(SCREEN_WIDTH + 1),
    localparam int NX_W         = vvp_pkg::ROT_W + W_BITS + vvp_pkg::FRAC_W,
    localparam int NY_W         = vvp_pkg::DIFF_W + W_BITS + vvp_pkg::FRAC_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vvp_pkg::cfg_t                 cfg,
    input  logic                          vertex_valid,
    output logic                          vertex_ready,
    input  vvp_pkg::vertex_t              vertex,
    output logic                          div_valid,
    input  logic                          div_ready,
    output logic [NX_W-1:0]               num_x,
    output logic [NY_W-1:0]               num_y,
    output logic [vvp_pkg::DEN_W-1:0]     den,
    output vvp_pkg::side_t                side
);

    localparam int DIFF_W  = vvp_pkg::DIFF_W;
    localparam int PROD_W  = vvp_pkg::PROD_W;
    localparam int SUM_W   = vvp_pkg::SUM_W;
    localparam int ROT_W   = vvp_pkg::ROT_W;
    localparam int BOUND_W = vvp_pkg::BOUND_W;
    localparam int FRAC_W  = vvp_pkg::FRAC_W;
    localparam int DEN_W   = vvp_pkg::DEN_W;
    localparam int CMP_W   = BOUND_W + 1;
    localparam logic [W_BITS-1:0] WIDTH_K = W_BITS'(SCREEN_WIDTH);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: viewer-relative position
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    // stage 2: rotation products
    logic signed [PROD_W-1:0] pxc2_reg, pzs2_reg, pxs2_reg, pzc2_reg;
    logic signed [DIFF_W-1:0] dy2_reg;
    // stage 3: rotated coordinates
    logic signed [ROT_W-1:0]  xr3_reg, zr3_reg;
    logic signed [DIFF_W-1:0] dy3_reg;
    // stage 4: field-of-view bound
    logic signed [BOUND_W-1:0] bound4_reg;
    logic signed [ROT_W-1:0]   xr4_reg;
    logic [vvp_pkg::COORD_W-1:0] zr4_reg;
    logic signed [DIFF_W-1:0]  dy4_reg;
    logic                      dist4_reg;
    // stage 5: divider operands
    logic [NX_W-1:0]           nx5_reg;
    logic [NY_W-1:0]           ny5_reg;
    logic [DEN_W-1:0]          den5_reg;
    vvp_pkg::side_t            side5_reg;

    logic signed [PROD_W-1:0]  pxc_next, pzs_next, pxs_next, pzc_next;
    logic signed [SUM_W-1:0]   sum_x, sum_z;
    logic signed [ROT_W-1:0]   xr3_next, zr_raw, zr3_next;
    logic signed [BOUND_W:0]   bound_full;
    logic signed [ROT_W+FRAC_W-1:0]  xs;
    logic signed [DIFF_W+FRAC_W-1:0] ys;
    logic signed [CMP_W-1:0]   bnd, nbnd;
    logic                      in_x, in_y;
    logic [ROT_W-1:0]          xmag;
    logic [DIFF_W-1:0]         ymag;
    logic [ROT_W+W_BITS-1:0]   xw;
    logic [DIFF_W+W_BITS-1:0]  yw;
    vvp_pkg::side_t            side5_next;

    assign rdy5         = !v5_reg || div_ready;
    assign rdy4         = !v4_reg || rdy5;
    assign rdy3         = !v3_reg || rdy4;
    assign rdy2         = !v2_reg || rdy3;
    assign rdy1         = !v1_reg || rdy2;
    assign vertex_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= vertex_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // rotation about the vertical axis, Q2.14 trig
    assign pxc_next = dx1_reg * cfg.cos_yaw;
    assign pzs_next = dz1_reg * cfg.sin_yaw;
    assign pxs_next = dx1_reg * cfg.sin_yaw;
    assign pzc_next = dz1_reg * cfg.cos_yaw;

    // arithmetic shift gives the floor
    assign sum_x    = pxc2_reg - pzs2_reg;
    assign sum_z    = pxs2_reg + pzc2_reg;
    assign xr3_next = sum_x[SUM_W-1:vvp_pkg::ROT_SHIFT];
    assign zr_raw   = sum_z[SUM_W-1:vvp_pkg::ROT_SHIFT];
    assign zr3_next = (zr_raw == '0) ? vvp_pkg::NEAR_DEPTH : zr_raw;

    assign bound_full = $signed({1'b0, cfg.tan_half_fov}) * zr3_reg;

    // strict field-of-view tests, Q.32 on both sides
    assign xs   = $signed({xr4_reg, {FRAC_W{1'b0}}});
    assign ys   = $signed({dy4_reg, {FRAC_W{1'b0}}});
    assign bnd  = bound4_reg;
    assign nbnd = -bnd;
    assign in_x = (xs < bnd) && (xs > nbnd);
    assign in_y = (ys < bnd) && (ys > nbnd);

    assign xmag = xr4_reg[ROT_W-1] ? $unsigned(-xr4_reg) : $unsigned(xr4_reg);
    assign ymag = dy4_reg[DIFF_W-1] ? $unsigned(-dy4_reg) : $unsigned(dy4_reg);
    assign xw   = xmag * WIDTH_K;
    assign yw   = ymag * WIDTH_K;

    always_comb
    begin
        side5_next.projected       = dist4_reg && in_x;
        side5_next.within_distance = dist4_reg;
        side5_next.within_x        = in_x;
        side5_next.within_y        = in_y;
        side5_next.neg_x           = xr4_reg[ROT_W-1];
        side5_next.neg_y           = dy4_reg[DIFF_W-1];
        side5_next.depth           = zr4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            dx1_reg <= DIFF_W'($signed(vertex.vertex_x)) - DIFF_W'($signed(cfg.viewer_x));
            dy1_reg <= DIFF_W'($signed(vertex.vertex_y)) - DIFF_W'($signed(cfg.viewer_y));
            dz1_reg <= DIFF_W'($signed(vertex.vertex_z)) - DIFF_W'($signed(cfg.viewer_z));
        end
        if (rdy2)
        begin
            pxc2_reg <= pxc_next;
            pzs2_reg <= pzs_next;
            pxs2_reg <= pxs_next;
            pzc2_reg <= pzc_next;
            dy2_reg  <= dy1_reg;
        end
        if (rdy3)
        begin
            xr3_reg <= xr3_next;
            zr3_reg <= zr3_next;
            dy3_reg <= dy2_reg;
        end
        if (rdy4)
        begin
            bound4_reg <= bound_full[BOUND_W-1:0];
            xr4_reg    <= xr3_reg;
            zr4_reg    <= zr3_reg[vvp_pkg::COORD_W-1:0];
            dy4_reg    <= dy3_reg;
            dist4_reg  <= zr3_reg < $signed({1'b0, cfg.far_plane});
        end
        if (rdy5)
        begin
            nx5_reg   <= {xw, {FRAC_W{1'b0}}};
            ny5_reg   <= {yw, {FRAC_W{1'b0}}};
            den5_reg  <= {bound4_reg[DEN_W-2:0], 1'b0};
            side5_reg <= side5_next;
        end
    end

    assign div_valid = v5_reg;
    assign num_x     = nx5_reg;
    assign num_y     = ny5_reg;
    assign den       = den5_reg;
    assign side      = side5_reg;

endmodule

`default_nettype wire

/* rtl/core/vvp_divider.sv */
`timescale 1ns / 1ps
`default_nettype none

module vvp_divider #(
    parameter  int SCREEN_WIDTH = vvp_pkg::SCREEN_WIDTH_DEF,
    localparam int W_BITS       = $clog2(SCREEN_WIDTH + 1),
    localparam int QX_W         = $clog2(SCREEN_WIDTH),
    localparam int NX_W         = vvp_pkg::ROT_W + W_BITS + vvp_pkg::FRAC_W,
    localparam int NY_W         = vvp_pkg::DIFF_W + W_BITS + vvp_pkg::FRAC_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          div_valid,
    output logic                          div_ready,
    input  logic [NX_W-1:0]               num_x,
    input  logic [NY_W-1:0]               num_y,
    input  logic [vvp_pkg::DEN_W-1:0]     den,
    input  vvp_pkg::side_t                side,
    output logic                          quot_valid,
    input  logic                          quot_ready,
    output logic [QX_W-1:0]               quot_x,
    output logic [vvp_pkg::SY_QW-1:0]     quot_y,
    output logic                          y_ovf,
    output vvp_pkg::side_t                side_q
);

    localparam int STEPS = vvp_pkg::SY_QW;
    localparam int DEN_W = vvp_pkg::DEN_W;
    localparam int OVF_W = (NY_W > DEN_W + STEPS) ? NY_W : DEN_W + STEPS;

    // stage 0 checks row overflow, stage k resolves quotient bit STEPS-k
    logic              vld_reg   [0:STEPS];
    logic              stage_rdy [0:STEPS+1];
    logic [NX_W-1:0]   rx_reg    [0:STEPS-1];
    logic [NY_W-1:0]   ry_reg    [0:STEPS-1];
    logic [DEN_W-1:0]  d_reg     [0:STEPS-1];
    logic [QX_W-1:0]   qx_reg    [0:STEPS];
    logic [STEPS-1:0]  qy_reg    [0:STEPS];
    logic              ovf_reg   [0:STEPS];
    vvp_pkg::side_t    side_reg  [0:STEPS];
    logic              ovf_next;

    // row quotient at or above 2^16 saturates the row anyway
    assign ovf_next = OVF_W'(num_y) >= (OVF_W'(den) << STEPS);

    assign stage_rdy[STEPS+1] = quot_ready;
    assign div_ready          = stage_rdy[0];

    genvar k;
    generate
        for (k = 0; k <= STEPS; k++)
        begin : g_rdy
            assign stage_rdy[k] = !vld_reg[k] || stage_rdy[k+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (stage_rdy[0])
            vld_reg[0] <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            rx_reg[0]   <= num_x;
            ry_reg[0]   <= num_y;
            d_reg[0]    <= den;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side;
        end
    end

    generate
        for (k = 1; k <= STEPS; k++)
        begin : g_step
            localparam int BIT = STEPS - k;
            localparam int CWY = (NY_W > DEN_W + BIT) ? NY_W : DEN_W + BIT;

            logic [CWY-1:0]   dy_sh, ry_ext, ry_diff;
            logic             take_y;
            logic [NY_W-1:0]  ry_next;
            logic [STEPS-1:0] qy_next;
            logic [NX_W-1:0]  rx_next;
            logic [QX_W-1:0]  qx_next;

            assign dy_sh   = CWY'(d_reg[k-1]) << BIT;
            assign ry_ext  = CWY'(ry_reg[k-1]);
            assign take_y  = ry_ext >= dy_sh;
            assign ry_diff = ry_ext - dy_sh;
            assign ry_next = take_y ? NY_W'(ry_diff) : ry_reg[k-1];

            always_comb
            begin
                qy_next      = qy_reg[k-1];
                qy_next[BIT] = take_y;
            end

            if (BIT < QX_W)
            begin : g_x
                localparam int CWX = (NX_W > DEN_W + BIT) ? NX_W : DEN_W + BIT;

                logic [CWX-1:0] dx_sh, rx_ext, rx_diff;
                logic           take_x;

                assign dx_sh   = CWX'(d_reg[k-1]) << BIT;
                assign rx_ext  = CWX'(rx_reg[k-1]);
                assign take_x  = rx_ext >= dx_sh;
                assign rx_diff = rx_ext - dx_sh;
                assign rx_next = take_x ? NX_W'(rx_diff) : rx_reg[k-1];

                always_comb
                begin
                    qx_next      = qx_reg[k-1];
                    qx_next[BIT] = take_x;
                end
            end
            else
            begin : g_xpass
                assign rx_next = rx_reg[k-1];
                assign qx_next = qx_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (stage_rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (stage_rdy[k])
                begin
                    qx_reg[k]   <= qx_next;
                    qy_reg[k]   <= qy_next;
                    ovf_reg[k]  <= ovf_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                end
            end

            if (k < STEPS)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (stage_rdy[k])
                    begin
                        rx_reg[k] <= rx_next;
                        ry_reg[k] <= ry_next;
                        d_reg[k]  <= d_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    assign quot_valid = vld_reg[STEPS];
    assign quot_x     = qx_reg[STEPS];
    assign quot_y     = qy_reg[STEPS];
    assign y_ovf      = ovf_reg[STEPS];
    assign side_q     = side_reg[STEPS];

endmodule

`default_nettype wire

/* rtl/core/vertex_view_projection.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                     payload
// --------  ------------------------------------------  ---------------------------
// vertex    vertex_valid / vertex_ready / vertex        vertex_t: world x, y, z
// result    result_valid / result_ready / result        result_t: screen pos, flags
// cfg       cfg_valid / cfg_ready / cfg_index/cfg_data  register index, write data
//
// one vertex transfer per cycle sustained while results are taken, one result per vertex, in order
// 5 transform stages, 17 divider stages, 1 output register
// the divider stages (overflow check plus one quotient bit per stage) set the depth
// every stage holds its item while the stage after it is full, so a stall on
// result_ready backs up stage by stage and drops or repeats nothing
// rst_n is asynchronous: empties the pipe and restores the register defaults
// cfg writes take effect at once and are always accepted

module vertex_view_projection #(
    parameter  int SCREEN_WIDTH = vvp_pkg::SCREEN_WIDTH_DEF,
    localparam int W_BITS       = $clog2(SCREEN_WIDTH + 1),
    localparam int QX_W         = $clog2(SCREEN_WIDTH),
    localparam int NX_W         = vvp_pkg::ROT_W + W_BITS + vvp_pkg::FRAC_W,
    localparam int NY_W         = vvp_pkg::DIFF_W + W_BITS + vvp_pkg::FRAC_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             vertex_valid,
    output logic                             vertex_ready,
    input  vvp_pkg::vertex_t                 vertex,
    output logic                             result_valid,
    input  logic                             result_ready,
    output vvp_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vvp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vvp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SX_W     = QX_W + 2;
    localparam int SY_QW    = vvp_pkg::SY_QW;
    localparam int SY_SUM_W = SY_QW + 2;

    localparam logic signed [SX_W-1:0]     HALF_W = SX_W'(SCREEN_WIDTH / 2);
    localparam logic signed [SY_SUM_W-1:0] HALF_H = SY_SUM_W'(vvp_pkg::SCREEN_HEIGHT / 2);
    localparam logic signed [SY_SUM_W-1:0] SY_MAX = SY_SUM_W'(32767);
    localparam logic signed [SY_SUM_W-1:0] SY_MIN = SY_SUM_W'(-32768);

    vvp_pkg::cfg_t   cfg_regs;

    // transform -> divider
    logic                       div_valid, div_ready;
    logic [NX_W-1:0]            num_x;
    logic [NY_W-1:0]            num_y;
    logic [vvp_pkg::DEN_W-1:0]  den;
    vvp_pkg::side_t             side;

    // divider -> output stage
    logic                       quot_valid, quot_ready;
    logic [QX_W-1:0]            quot_x;
    logic [SY_QW-1:0]           quot_y;
    logic                       y_ovf;
    vvp_pkg::side_t             side_q;

    // output stage
    logic signed [SX_W-1:0]     qx_s, sx_sum;
    logic [SY_QW-1:0]           qy_mag;
    logic signed [SY_SUM_W-1:0] qy_s, sy_sum, sy_sat;
    vvp_pkg::result_t           result_next;
    vvp_pkg::result_t           result_reg;
    logic                       result_valid_reg;

    vvp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg_regs)
    );

    // subtract viewer, rotate, bound, field-of-view tests, divider operands
    vvp_transform #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_xform (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_regs),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .div_valid    (div_valid),
        .div_ready    (div_ready),
        .num_x        (num_x),
        .num_y        (num_y),
        .den          (den),
        .side         (side)
    );

    // column and row quotients, restoring, one bit per stage
    vvp_divider #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .div_valid  (div_valid),
        .div_ready  (div_ready),
        .num_x      (num_x),
        .num_y      (num_y),
        .den        (den),
        .side       (side),
        .quot_valid (quot_valid),
        .quot_ready (quot_ready),
        .quot_x     (quot_x),
        .quot_y     (quot_y),
        .y_ovf      (y_ovf),
        .side_q     (side_q)
    );

    // column: center plus signed quotient, truncated toward zero
    assign qx_s   = $signed(SX_W'(quot_x));
    assign sx_sum = HALF_W + (side_q.neg_x ? -qx_s : qx_s);

    // row: an overflowed quotient is pinned high enough to saturate either way
    assign qy_mag = y_ovf ? {SY_QW{1'b1}} : quot_y;
    assign qy_s   = $signed({2'b00, qy_mag});
    assign sy_sum = HALF_H + (side_q.neg_y ? -qy_s : qy_s);

    always_comb
    begin
        if (sy_sum > SY_MAX)
            sy_sat = SY_MAX;
        else if (sy_sum < SY_MIN)
            sy_sat = SY_MIN;
        else
            sy_sat = sy_sum;
    end

    always_comb
    begin
        result_next.projected       = side_q.projected;
        result_next.within_distance = side_q.within_distance;
        result_next.within_x        = side_q.within_x;
        result_next.within_y        = side_q.within_y;
        result_next.dot_visible     = side_q.projected && side_q.within_y;
        if (side_q.projected)
        begin
            result_next.screen_x   = vvp_pkg::SX_OUT_W'(sx_sum);
            result_next.screen_y   = sy_sat[vvp_pkg::SY_OUT_W-1:0];
            result_next.view_depth = $signed(side_q.depth);
        end
        else
        begin
            // off-screen marker values
            result_next.screen_x   = '1;
            result_next.screen_y   = '1;
            result_next.view_depth = vvp_pkg::NO_PROJ_DEPTH;
        end
    end

    // output register: loads whenever it is empty or its result is taken
    assign quot_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (quot_ready)
            result_valid_reg <= quot_valid;
    end

    always_ff @(posedge clk)
    begin
        if (quot_ready)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* tb/tb_vertex_view_projection.sv */
`timescale 1ns / 1ps

module tb_vertex_view_projection;
    import vvp_pkg::*;

    // timing of the run
    localparam int  DRAIN_CYCLES = 40;          // longer than the pipe is deep
    localparam int  HOLD_CYCLES  = 300;         // long receiver hold-off
    localparam real TIMEOUT_NS   = 5_000_000.0; // hang guard limit

    // fixed-point helpers for the predictor
    localparam longint MIN_DEPTH_Q16 = 655;     // 0.01 in Q16.16
    localparam longint UNSEEN_DEPTH  = -65536;  // -1.0 in Q16.16
    localparam longint HALF_W        = SCREEN_WIDTH_DEF / 2;
    localparam longint HALF_H        = SCREEN_HEIGHT / 2;
    localparam longint ROW_SCALE     = longint'(SCREEN_WIDTH_DEF) * 65536;

    // index past the last register, writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // register values right after reset
    localparam cfg_t RESET_VIEW = '{
        viewer_x:     32'sd0,
        viewer_y:     32'sd0,
        viewer_z:     32'sd0,
        cos_yaw:      16'sd16384,
        sin_yaw:      16'sd0,
        tan_half_fov: 24'd65536,
        far_plane:    31'd6553600
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   vertex_valid;
    logic                   vertex_ready;
    vertex_t                vertex;
    logic                   result_valid;
    logic                   result_ready;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor copy of the view registers
    cfg_t    view_regs = RESET_VIEW;
    // predicted results still owed by the block, oldest first
    result_t pending_results[$];
    int      mismatches   = 0;
    // random idling on both channels, off for burst stretches
    bit      gaps_on      = 1'b1;
    // asks the result side for one long hold-off
    bit      hold_request = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vertex_view_projection DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor: viewer-relative, yaw rotation, frustum tests, projection
    // all products fit in 64 bits: |xr| < 2^35, tan < 2^24
    // ------------------------------------------------------------------
    function automatic result_t project_vertex(input vertex_t v);
        longint  rel_x, rel_y, rel_z;
        longint  cos_q, sin_q, tan_q;
        longint  xr, zr, bound, den, col, row, depth;
        logic    near_ok, x_ok, y_ok, hit;
        result_t r;
        rel_x = longint'(v.vertex_x) - longint'(view_regs.viewer_x);
        rel_y = longint'(v.vertex_y) - longint'(view_regs.viewer_y);
        rel_z = longint'(v.vertex_z) - longint'(view_regs.viewer_z);
        cos_q = longint'(view_regs.cos_yaw);
        sin_q = longint'(view_regs.sin_yaw);
        tan_q = longint'(view_regs.tan_half_fov);
        // Q2.14 products, floor back to Q16.16
        xr = (rel_x * cos_q - rel_z * sin_q) >>> 14;
        zr = (rel_x * sin_q + rel_z * cos_q) >>> 14;
        // depth of exactly zero is pushed out to the near value
        if (zr == 0)
            zr = MIN_DEPTH_Q16;
        // bounds compared in Q.32
        bound   = tan_q * zr;
        near_ok = zr < longint'(view_regs.far_plane);
        x_ok    = (xr * 65536 < bound) && (xr * 65536 > -bound);
        y_ok    = (rel_y * 65536 < bound) && (rel_y * 65536 > -bound);
        hit     = near_ok && x_ok;
        col     = -1;
        row     = -1;
        depth   = UNSEEN_DEPTH;
        if (hit)
        begin
            // division truncates toward zero, row scales by width too
            den = 2 * bound;
            col = HALF_W + (xr * ROW_SCALE) / den;
            row = HALF_H + (rel_y * ROW_SCALE) / den;
            if (row > 32767)
                row = 32767;
            else if (row < -32768)
                row = -32768;
            depth = zr;
        end
        r.screen_x        = SX_OUT_W'(col);
        r.screen_y        = SY_OUT_W'(row);
        r.view_depth      = COORD_W'(depth);
        r.projected       = hit;
        r.within_distance = near_ok;
        r.within_x        = x_ok;
        r.within_y        = y_ok;
        r.dot_visible     = hit && y_ok;
        return r;
    endfunction

    function automatic vertex_t vtx(input int x, input int y, input int z);
        vertex_t v;
        v.vertex_x = x;
        v.vertex_y = y;
        v.vertex_z = z;
        return v;
    endfunction

    // mostly short gaps, some long ones, none while gaps are off
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // viewer coordinate: usually near the origin, sometimes anywhere
    function automatic int viewer_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return int'(longint'($urandom_range(0, 1000 << 16)) - (500 << 16));
    endfunction

    function automatic cfg_t random_view();
        cfg_t v;
        real  ang;
        ang        = real'($urandom_range(0, 359)) * 3.14159265358979 / 180.0;
        v.viewer_x = viewer_coord();
        v.viewer_y = viewer_coord();
        v.viewer_z = viewer_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            // unnormalized trig, any 16-bit pattern
            v.cos_yaw = 16'($urandom);
            v.sin_yaw = 16'($urandom);
        end
        else
        begin
            v.cos_yaw = 16'($rtoi($cos(ang) * 16384.0));
            v.sin_yaw = 16'($rtoi($sin(ang) * 16384.0));
        end
        v.tan_half_fov = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(1 << 13, 3 << 16));
        v.far_plane    = ($urandom_range(0, 4) == 0) ? 31'($urandom)
                                                     : 31'($urandom_range(1 << 16, 4000 << 16));
        return v;
    endfunction

    // most vertices are placed in view space around the frustum and rotated
    // back into the world, so that the flags and the projection get exercised
    function automatic vertex_t random_vertex();
        longint  cos_q, sin_q, tan_q;
        longint  depth, lim, lat, rx, ry, rz;
        int      roll;
        vertex_t v;
        roll  = $urandom_range(0, 99);
        cos_q = longint'(view_regs.cos_yaw);
        sin_q = longint'(view_regs.sin_yaw);
        tan_q = longint'(view_regs.tan_half_fov);
        if (roll < 20)
        begin
            // noise: any coordinates at all
            v.vertex_x = $urandom;
            v.vertex_y = $urandom;
            v.vertex_z = $urandom;
            return v;
        end
        if (roll < 32)
        begin
            // right at the viewer, often a zero depth
            rx = longint'($urandom_range(0, 8)) - 4;
            ry = longint'($urandom_range(0, 8)) - 4;
            rz = longint'($urandom_range(0, 8)) - 4;
        end
        else
        begin
            if ($urandom_range(0, 7) == 0)
                depth = longint'($urandom_range(0, 8));
            else
                depth = longint'($urandom) % (longint'(view_regs.far_plane) * 5 / 4 + 2);
            // half width of the view at that depth, a bit past the edge
            lim = tan_q * depth / 65536 * 9 / 8 + 1;
            if (lim > 64'sd2147483647)
                lim = 64'sd2147483647;
            lat = longint'($urandom) % (2 * lim + 1) - lim;
            ry  = longint'($urandom) % (2 * lim + 1) - lim;
            rx  = (lat * cos_q + depth * sin_q) >>> 14;
            rz  = (depth * cos_q - lat * sin_q) >>> 14;
        end
        v.vertex_x = COORD_W'(longint'(view_regs.viewer_x) + rx);
        v.vertex_y = COORD_W'(longint'(view_regs.viewer_y) + ry);
        v.vertex_z = COORD_W'(longint'(view_regs.viewer_z) + rz);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // vertex side: one transfer per call, valid held until accepted
    // valid is only lowered when a gap follows, so it never toggles in a step
    // ------------------------------------------------------------------
    task automatic send_vertex(input vertex_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            vertex_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vertex_valid <= 1'b1;
        vertex       <= v;
        // handshake sampled mid-cycle, transfer happens at the next edge
        @(negedge clk);
        while (!vertex_ready)
            @(negedge clk);
        pending_results.push_back(project_vertex(v));
        @(posedge clk);
    endtask

    // lets everything owed come out, then lets the pipe sit quiet before returning
    task automatic drain_pipeline();
        vertex_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write; the predictor copy follows at the transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        case (idx)
            REG_VIEWER_X:     view_regs.viewer_x     = data;
            REG_VIEWER_Y:     view_regs.viewer_y     = data;
            REG_VIEWER_Z:     view_regs.viewer_z     = data;
            REG_COS_YAW:      view_regs.cos_yaw      = data[TRIG_W-1:0];
            REG_SIN_YAW:      view_regs.sin_yaw      = data[TRIG_W-1:0];
            REG_TAN_HALF_FOV: view_regs.tan_half_fov = data[TAN_W-1:0];
            REG_FAR_PLANE:    view_regs.far_plane    = data[FAR_W-1:0];
            default:          ;
        endcase
        @(posedge clk);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // writes every register, junk in the unused upper data bits
    task automatic apply_view(input cfg_t v);
        write_reg(REG_VIEWER_X, v.viewer_x, 1'b0);
        write_reg(REG_VIEWER_Y, v.viewer_y, 1'b0);
        write_reg(REG_VIEWER_Z, v.viewer_z, 1'b0);
        write_reg(REG_COS_YAW, {16'($urandom), v.cos_yaw}, 1'b0);
        write_reg(REG_SIN_YAW, {16'($urandom), v.sin_yaw}, 1'b0);
        write_reg(REG_TAN_HALF_FOV, {8'($urandom), v.tan_half_fov}, 1'b0);
        write_reg(REG_FAR_PLANE, {1'($urandom), v.far_plane}, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d (0x%h), got %0d (0x%h)",
                   field, $signed(want), want, $signed(got), got);
            mismatches++;
        end
    endfunction

    // each result transfer against the oldest prediction
    always @(negedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no vertex outstanding: 0x%h", result);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("screen_x", 32'(want.screen_x), 32'(result.screen_x));
                check_field("screen_y", 32'(want.screen_y), 32'(result.screen_y));
                check_field("view_depth", want.view_depth, result.view_depth);
                check_field("projected", 32'(want.projected), 32'(result.projected));
                check_field("within_distance", 32'(want.within_distance),
                            32'(result.within_distance));
                check_field("within_x", 32'(want.within_x), 32'(result.within_x));
                check_field("within_y", 32'(want.within_y), 32'(result.within_y));
                check_field("dot_visible", 32'(want.dot_visible), 32'(result.dot_visible));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register defaults after reset: tan 1.0, far 100.0, no yaw, viewer at origin
    // so rotated x and depth equal world x and z
    task automatic test_reset_defaults();
        send_vertex(vtx(0, 0, 0));                           // zero depth, centered
        send_vertex(vtx(0, 0, 10 << 16));
        send_vertex(vtx(10 << 16, 0, 10 << 16));             // x on the right edge
        send_vertex(vtx((10 << 16) - 1, 0, 10 << 16));       // just inside right
        send_vertex(vtx(-(10 << 16) + 1, 0, 10 << 16));      // just inside left
        send_vertex(vtx(-(10 << 16), 0, 10 << 16));          // x on the left edge
        send_vertex(vtx(0, 10 << 16, 10 << 16));             // y on the edge, no dot
        send_vertex(vtx(0, -(10 << 16) + 1, 10 << 16));
        send_vertex(vtx(0, 32'h7FFF_FFFF, 1 << 16));         // row clamps high
        send_vertex(vtx(0, 32'h8000_0000, 1 << 16));         // row clamps low
        send_vertex(vtx(0, 0, 100 << 16));                   // on the far plane
        send_vertex(vtx(0, 0, (100 << 16) - 1));
        send_vertex(vtx(0, 0, 1));                           // smallest depth
        send_vertex(vtx(0, 0, -(5 << 16)));                  // behind the viewer
        send_vertex(vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_vertex(vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_vertex(vtx(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA));
        send_vertex(vtx(5 << 16, -(3 << 16), 20 << 16));
    endtask

    // zero tangent: nothing lies inside the view, so nothing is projected
    task automatic test_zero_tangent();
        cfg_t v;
        v              = RESET_VIEW;
        v.tan_half_fov = '0;
        drain_pipeline();
        apply_view(v);
        send_vertex(vtx(0, 0, 0));
        send_vertex(vtx(0, 0, 10 << 16));
        send_vertex(vtx(1, 1, 1 << 16));
        repeat (3) send_vertex(random_vertex());
    endtask

    task automatic extreme_vertices();
        send_vertex(vtx(0, 0, 0));
        send_vertex(vtx(view_regs.viewer_x, view_regs.viewer_y, view_regs.viewer_z));
        send_vertex(vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_vertex(vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_vertex(vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_vertex(vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_vertex(vtx(1 << 16, 1 << 16, 1 << 16));
    endtask

    // registers at their extremes, and a write to the unused index
    task automatic test_config_extremes();
        cfg_t v;
        v = '{viewer_x: 32'sh7FFF_FFFF, viewer_y: 32'sh8000_0000, viewer_z: 32'sh8000_0000,
              cos_yaw: 16'sh8000, sin_yaw: 16'sh7FFF, tan_half_fov: 24'hFF_FFFF,
              far_plane: 31'h7FFF_FFFF};
        drain_pipeline();
        apply_view(v);
        extreme_vertices();

        v = '{viewer_x: 32'sh8000_0000, viewer_y: 32'sh7FFF_FFFF, viewer_z: 32'sh7FFF_FFFF,
              cos_yaw: 16'sh7FFF, sin_yaw: 16'sh8000, tan_half_fov: 24'd1,
              far_plane: 31'd0};
        drain_pipeline();
        write_reg(REG_UNUSED, $urandom, 1'b1);
        apply_view(v);
        extreme_vertices();

        // quarter-turn style trig at the nominal limits, widest view
        v = '{viewer_x: 32'sd0, viewer_y: 32'sd0, viewer_z: 32'sd0,
              cos_yaw: -16'sd16384, sin_yaw: 16'sd16384, tan_half_fov: 24'hFF_FFFF,
              far_plane: 31'h7FFF_FFFF};
        drain_pipeline();
        apply_view(v);
        extreme_vertices();
    endtask

    // random views, each followed by a block of vertices; every third block
    // runs both channels without idling
    task automatic test_random_views();
        for (int k = 0; k < 8; k++)
        begin
            drain_pipeline();
            apply_view(random_view());
            gaps_on = (k % 3 != 2);
            repeat (90) send_vertex(random_vertex());
        end
        gaps_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, the pipe fills
    // and vertex_ready must drop until results drain again
    task automatic test_backpressure();
        drain_pipeline();
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (80) send_vertex(random_vertex());
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        vertex_valid = 1'b0;
        vertex       = '0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_tangent();
        test_config_extremes();
        test_random_views();
        test_backpressure();
        drain_pipeline();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
